>>> rtl/core/pisq_pkg.sv
package pisq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int POS_W     = 4;
    localparam int ID_W      = 27;
    localparam int NAME_W    = 32;
    localparam int SCORE_W   = 14;
    localparam int FILL_W    = 5;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BEYOND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHRD,
        ST_SHWR,
        ST_WRNEW,
        ST_RDHD,
        ST_RDWT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [NAME_W-1:0]  name_tag;
        logic [SCORE_W-1:0] score;
    } t_rec;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        logic [ID_W-1:0]    record_id;
        logic [NAME_W-1:0]  name_tag;
        logic [SCORE_W-1:0] score;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [FILL_W-1:0]  fill_count;
        logic [ID_W-1:0]    out_id;
        logic [NAME_W-1:0]  out_name_tag;
        logic [SCORE_W-1:0] out_score;
    } t_out;

endpackage

>>> rtl/core/pisq_mem.sv
module pisq_mem
    import pisq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rec          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pisq_seq.sv
module pisq_seq
    import pisq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in           i_in,
    output logic          o_done,
    output t_out          o_res,
    input  logic          i_take,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output t_rec          o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  t_rec          i_mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    t_kind           r_op, n_op;
    t_status         r_status, n_status;
    logic [AW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_lim, n_lim;
    logic            r_shift, n_shift;
    t_rec            r_new, n_new;
    t_rec            r_res, n_res;

    logic [PW-1:0]   pos_e;
    logic [PW-1:0]   cnt_e;
    logic [PW-1:0]   tgt_e;
    logic            full;
    logic            accept;

    assign pos_e  = PW'(i_in.position);
    assign cnt_e  = PW'(r_cnt);
    assign full   = (r_cnt == CW'(DEPTH));
    assign accept = i_in_valid && o_in_ready;
    assign tgt_e  = ((i_in.kind == KIND_APPEND) || (pos_e >= cnt_e)) ? cnt_e : pos_e;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_status    = r_status;
        n_src       = r_src;
        n_lim       = r_lim;
        n_shift     = r_shift;
        n_new       = r_new;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_done      = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_lim;
        o_mem_wdata = r_new;
        o_mem_raddr = r_src;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = i_in.kind;
                    n_shift  = 1'b0;
                    n_status = STAT_OK;
                    n_new    = '{id: i_in.record_id, name_tag: i_in.name_tag,
                                 score: i_in.score};
                    case (i_in.kind)
                        KIND_APPEND, KIND_INSERT: begin
                            if (full) begin
                                n_status = STAT_FULL;
                                n_state  = ST_RDHD;
                            end else begin
                                n_lim = AW'(tgt_e);
                                n_cnt = r_cnt + CW'(1);
                                n_src = AW'(r_cnt - CW'(1));
                                if (cnt_e > tgt_e) begin
                                    n_state = ST_SHRD;
                                end else begin
                                    n_state = ST_WRNEW;
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = STAT_EMPTY;
                                n_res    = '0;
                                n_state  = ST_DONE;
                            end else begin
                                n_cnt   = r_cnt - CW'(1);
                                n_lim   = AW'(r_cnt - CW'(1));
                                n_src   = AW'(1);
                                n_shift = (r_cnt > CW'(1));
                                n_state = ST_RDHD;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_status = STAT_EMPTY;
                                n_res    = '0;
                                n_state  = ST_DONE;
                            end else if (pos_e >= cnt_e) begin
                                n_status = STAT_BEYOND;
                                n_res    = '0;
                                n_state  = ST_DONE;
                            end else begin
                                n_lim   = AW'(pos_e);
                                n_state = ST_RDHD;
                            end
                        end
                    endcase
                end
            end
            ST_SHRD: begin
                o_mem_raddr = r_src;
                n_state     = ST_SHWR;
            end
            ST_SHWR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                if (r_op == KIND_REMOVE) begin
                    o_mem_waddr = r_src - AW'(1);
                    n_src       = r_src + AW'(1);
                end else begin
                    o_mem_waddr = r_src + AW'(1);
                    n_src       = r_src - AW'(1);
                end
                if (r_src == r_lim) begin
                    n_state = (r_op == KIND_REMOVE) ? ST_DONE : ST_WRNEW;
                end else begin
                    n_state = ST_SHRD;
                end
            end
            ST_WRNEW: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_lim;
                o_mem_wdata = r_new;
                n_state     = ST_RDHD;
            end
            ST_RDHD: begin
                o_mem_raddr = (r_op == KIND_READ) ? r_lim : '0;
                n_state     = ST_RDWT;
            end
            ST_RDWT: begin
                n_res   = i_mem_rdata;
                n_state = r_shift ? ST_SHRD : ST_DONE;
            end
            ST_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_src    <= n_src;
        r_lim    <= n_lim;
        r_shift  <= n_shift;
        r_new    <= n_new;
        r_res    <= n_res;
    end

    assign o_res = '{status: r_status, fill_count: FILL_W'(r_cnt),
                     out_id: r_res.id, out_name_tag: r_res.name_tag,
                     out_score: r_res.score};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !o_mem_we)
        else $error("memory written outside an operation");

    a_insert_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHWR && r_op != KIND_REMOVE) |-> (r_src >= r_lim))
        else $error("insert shift ran past target slot");

    a_remove_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_REMOVE && r_cnt != '0)
        |=> (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("remove did not drop the count");

endmodule

>>> rtl/core/positional_insert_shift_queue_core.sv
// fixed-depth record queue with positional insert, held in a single-port-write memory
// input channel: i_in_valid / o_in_ready carry one transaction (kind, position, record)
// output channel: o_out_valid / i_out_ready carry one result transaction per input
// a small sequencer moves one entry at a time through the memory ports (ST_SHRD, ST_SHWR)
// steps from accept to result, in order:
//   append / insert: move entries behind the target slot up, write the record, read head
//   remove: read the head, then move the entries left after it down one slot
//   read: read the slot at position; empty and beyond-tail: none; full: read the head
// one transaction is worked on at a time; o_in_ready is high only while the
// sequencer is idle, so no new transaction is taken before the last result leaves it
// a finished result sits in the output register; a new transaction is accepted
// while it waits, and the next result holds in the sequencer until the
// receiver takes the previous one
// reset (i_rst_n low at a clock edge) empties the queue and drops any pending result;
// memory contents are not cleared, entries past the fill count are never reported
module positional_insert_shift_queue_core
    import pisq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int AW = $clog2(DEPTH);

    logic          seq_done;
    t_out          seq_res;
    logic          take;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_rec          mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_rec          mem_rdata;

    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    assign take = !r_out_valid || i_out_ready;

    pisq_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_done      (seq_done),
        .o_res       (seq_res),
        .i_take      (take),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    pisq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (seq_done && take) begin
            n_out_valid = 1'b1;
            n_out       = seq_res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
